@@ hw/rtl/tph_pkg.sv @@
// ----------------------------------------------------------------------------
// tph_pkg
// Shared types and constants for the time-proportioned PID heater controller.
// ----------------------------------------------------------------------------
package tph_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned INTEG_W = 32;
  // gain_deriv * |delta err| * 1000 stays below 2^39
  localparam int unsigned NUM_W   = 39;

  localparam logic [10:0] TARGET_CAP = 11'd1400;
  localparam int unsigned OPEN_BIT   = 2;
  localparam int unsigned MS_PER_S   = 1000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_TARGET     = 3'd0,
    CFG_GAIN_PROP  = 3'd1,
    CFG_GAIN_INTEG = 3'd2,
    CFG_GAIN_DERIV = 3'd3,
    CFG_CYCLE      = 3'd4,
    CFG_MIN_ON     = 3'd5,
    CFG_GAP        = 3'd6,
    CFG_BAND       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CALC,
    T_SWITCH
  } top_state_e;

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL,
    P_DIV,
    P_INTEG,
    P_SUM,
    P_CLAMP
  } pid_state_e;

  typedef struct packed {
    logic [10:0] target;
    logic [15:0] gain_prop;
    logic [15:0] gain_integ;
    logic [15:0] gain_deriv;
    logic [15:0] cycle_ms;
    logic [14:0] min_on_ms;
    logic [11:0] integ_band;
  } pid_cfg_t;

endpackage

@@ hw/rtl/tph_pid.sv @@
// ----------------------------------------------------------------------------
// tph_pid
// Bit-serial PID duty calculation: shift-add multiplies, restoring divide
// for the derivative term, integral saturation and duty clamping.
// ----------------------------------------------------------------------------
module tph_pid #(
  parameter int unsigned COUNT_BITS = tph_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [11:0]               temp_i,
  input  tph_pkg::pid_cfg_t         cfg_i,
  input  logic [COUNT_BITS-1:0]     elapsed_i,
  output logic                      done_o,
  output logic [15:0]               duty_o
);

  localparam int unsigned MP_W  = 12 + tph_pkg::GAIN_W;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned RAW_W = tph_pkg::NUM_W + 3;

  tph_pkg::pid_state_e state_q, state_d;

  logic signed [tph_pkg::ERR_W-1:0]   last_err_q, last_err_d;
  logic signed [tph_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic [11:0]                aerr_q, aerr_d;
  logic                       eneg_q, eneg_d;
  logic                       dneg_q, dneg_d;
  logic                       ien_q, ien_d;
  logic [15:0]                gp_q, gp_d, gi_q, gi_d, gd_q, gd_d;
  logic [MP_W-1:0]            mp_q, mp_d, pacc_q, pacc_d, iacc_q, iacc_d;
  logic [tph_pkg::NUM_W-1:0]  md_q, md_d, dacc_q, dacc_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]      rem_q, rem_d, div_q, div_d;
  logic signed [RAW_W-1:0]    raw_q, raw_d;

  // start-cycle terms
  logic signed [tph_pkg::ERR_W-1:0] err;
  logic signed [tph_pkg::ERR_W:0]   delta;
  logic [12:0]                      mag;
  // divide step
  logic [COUNT_BITS+1:0]            diff;
  // integral and sum
  logic signed [tph_pkg::INTEG_W:0] isum;
  logic signed [tph_pkg::INTEG_W:0] iterm;
  logic signed [RAW_W-1:0]          pterm, dterm;
  // clamp
  logic [RAW_W-9:0]                 shr;
  logic [RAW_W-9:0]                 dv1;
  logic signed [16:0]               cmn;

  always_comb begin
    err   = $signed({3'b000, cfg_i.target}) - $signed({2'b00, temp_i});
    delta = $signed({err[tph_pkg::ERR_W-1], err}) -
            $signed({last_err_q[tph_pkg::ERR_W-1], last_err_q});
    mag   = delta[tph_pkg::ERR_W] ? 13'(-delta) : 13'(delta);
    diff  = {1'b0, rem_q, dacc_q[tph_pkg::NUM_W-1]} - {2'b00, div_q};
    iterm = eneg_q ? -$signed({5'b0, iacc_q}) : $signed({5'b0, iacc_q});
    isum  = $signed({integ_q[tph_pkg::INTEG_W-1], integ_q}) + iterm;
    pterm = eneg_q ? -$signed(RAW_W'(pacc_q)) : $signed(RAW_W'(pacc_q));
    dterm = dneg_q ? -$signed(RAW_W'(dacc_q)) : $signed(RAW_W'(dacc_q));
    shr   = raw_q[RAW_W-1:8];
    cmn   = $signed({1'b0, cfg_i.cycle_ms}) - $signed({2'b00, cfg_i.min_on_ms});
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tph_pkg::P_IDLE:  if (start_i) state_d = tph_pkg::P_MUL;
      tph_pkg::P_MUL:   if (cnt_q == CNT_W'(tph_pkg::GAIN_W - 1)) state_d = tph_pkg::P_DIV;
      tph_pkg::P_DIV:   if (cnt_q == CNT_W'(tph_pkg::NUM_W - 1)) state_d = tph_pkg::P_INTEG;
      tph_pkg::P_INTEG: state_d = tph_pkg::P_SUM;
      tph_pkg::P_SUM:   state_d = tph_pkg::P_CLAMP;
      tph_pkg::P_CLAMP: state_d = tph_pkg::P_IDLE;
      default:          state_d = tph_pkg::P_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    last_err_d = last_err_q;
    integ_d    = integ_q;
    aerr_d     = aerr_q;
    eneg_d     = eneg_q;
    dneg_d     = dneg_q;
    ien_d      = ien_q;
    gp_d       = gp_q;
    gi_d       = gi_q;
    gd_d       = gd_q;
    mp_d       = mp_q;
    md_d       = md_q;
    pacc_d     = pacc_q;
    iacc_d     = iacc_q;
    dacc_d     = dacc_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    div_d      = div_q;
    raw_d      = raw_q;
    done_o     = 1'b0;
    duty_o     = '0;
    dv1        = '0;
    unique case (state_q)
      tph_pkg::P_IDLE: begin
        if (start_i) begin
          eneg_d     = err[tph_pkg::ERR_W-1];
          aerr_d     = err[tph_pkg::ERR_W-1] ? 12'(-err) : 12'(err);
          ien_d      = (aerr_d < cfg_i.integ_band);
          dneg_d     = delta[tph_pkg::ERR_W];
          md_d       = tph_pkg::NUM_W'(mag) * tph_pkg::NUM_W'(tph_pkg::MS_PER_S);
          mp_d       = MP_W'(aerr_d);
          gp_d       = cfg_i.gain_prop;
          gi_d       = cfg_i.gain_integ;
          gd_d       = cfg_i.gain_deriv;
          pacc_d     = '0;
          iacc_d     = '0;
          dacc_d     = '0;
          cnt_d      = '0;
          div_d      = elapsed_i;
          last_err_d = err;
        end
      end
      tph_pkg::P_MUL: begin
        if (gp_q[0]) pacc_d = pacc_q + mp_q;
        if (gi_q[0]) iacc_d = iacc_q + mp_q;
        if (gd_q[0]) dacc_d = dacc_q + md_q;
        mp_d  = {mp_q[MP_W-2:0], 1'b0};
        md_d  = {md_q[tph_pkg::NUM_W-2:0], 1'b0};
        gp_d  = {1'b0, gp_q[15:1]};
        gi_d  = {1'b0, gi_q[15:1]};
        gd_d  = {1'b0, gd_q[15:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(tph_pkg::GAIN_W - 1)) begin
          cnt_d = '0;
          rem_d = '0;
        end
      end
      tph_pkg::P_DIV: begin
        // restoring divide, quotient bits shift into dacc
        if (!diff[COUNT_BITS+1]) begin
          rem_d  = diff[COUNT_BITS-1:0];
          dacc_d = {dacc_q[tph_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_d  = diff[COUNT_BITS-1:0] + div_q;
          dacc_d = {dacc_q[tph_pkg::NUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      tph_pkg::P_INTEG: begin
        if (ien_q) begin
          if (isum[tph_pkg::INTEG_W] != isum[tph_pkg::INTEG_W-1]) begin
            integ_d = isum[tph_pkg::INTEG_W] ? {1'b1, {(tph_pkg::INTEG_W-1){1'b0}}}
                                             : {1'b0, {(tph_pkg::INTEG_W-1){1'b1}}};
          end else begin
            integ_d = isum[tph_pkg::INTEG_W-1:0];
          end
        end
      end
      tph_pkg::P_SUM: begin
        raw_d = pterm + RAW_W'(integ_q) + dterm;
      end
      tph_pkg::P_CLAMP: begin
        done_o = 1'b1;
        if (raw_q[RAW_W-1]) dv1 = '0;
        else if (shr < (RAW_W-8)'(cfg_i.min_on_ms)) dv1 = (RAW_W-8)'(cfg_i.min_on_ms);
        else dv1 = shr;
        if (dv1 > (RAW_W-8)'(cfg_i.cycle_ms)) duty_o = cfg_i.cycle_ms;
        else if (cmn < 0) duty_o = '0;
        else if (dv1 > (RAW_W-8)'(cmn[15:0])) duty_o = cmn[15:0];
        else duty_o = dv1[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tph_pkg::P_IDLE;
      last_err_q <= '0;
      integ_q    <= '0;
    end else begin
      state_q    <= state_d;
      last_err_q <= last_err_d;
      integ_q    <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aerr_q <= aerr_d;
    eneg_q <= eneg_d;
    dneg_q <= dneg_d;
    ien_q  <= ien_d;
    gp_q   <= gp_d;
    gi_q   <= gi_d;
    gd_q   <= gd_d;
    mp_q   <= mp_d;
    md_q   <= md_d;
    pacc_q <= pacc_d;
    iacc_q <= iacc_d;
    dacc_q <= dacc_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    raw_q  <= raw_d;
  end

endmodule

@@ hw/rtl/time_proportioned_pid_heater_top.sv @@
// ----------------------------------------------------------------------------
// time_proportioned_pid_heater_top
// Thermocouple sequencer, PID duty calculation and time-proportioned heater.
// ----------------------------------------------------------------------------
// One result per transfer. A start, stop, no-op or tick without a valid
// sensor read goes from the input transfer straight to the switch step. A
// tick that reads a good sensor word first runs the PID calculation: the
// bit-serial gain multiplies, the restoring divide of the derivative term,
// then integral, sum and clamp steps. Input is stalled while an item is in
// work; a finished result waits in the output register while the next item enters.
module time_proportioned_pid_heater_top #(
  parameter int unsigned COUNT_BITS = tph_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] sensor_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        heater_on_o,
  output logic        sensor_select_o,
  output logic        sensor_read_o,
  output logic [11:0] temperature_o,
  output logic        open_circuit_o,
  output logic [15:0] duty_ms_o,
  output logic        running_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  tph_pkg::top_state_e state_q, state_d;
  tph_pkg::pid_cfg_t   cfg_q;
  logic [15:0]         gap_q;

  logic                  active_q, active_d, heater_q, heater_d, sel_q, sel_d;
  logic                  fault_q, fault_d, tick_q, tick_d, read_q, read_d;
  logic [COUNT_BITS-1:0] sw_q, sw_d, rd_q, rd_d, ss_q, ss_d;
  logic [15:0]           duty_q, duty_d;
  logic [11:0]           temp_q, temp_d;

  logic        ov_q, ov_d;
  logic        o_heater_q, o_sel_q, o_read_q, o_fault_q, o_run_q;
  logic [11:0] o_temp_q;
  logic [15:0] o_duty_q;
  logic        load_out;

  logic        accept;
  logic        pid_start, pid_done;
  logic [15:0] pid_duty;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (c != CNT_MAX) ? c + COUNT_BITS'(1) : c;
  endfunction

  assign accept     = in_valid_i && (state_q == tph_pkg::T_IDLE);
  assign in_stall_o = (state_q != tph_pkg::T_IDLE);
  assign load_out   = (state_q == tph_pkg::T_SWITCH) && (!ov_q || !out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target     <= 11'd800;
      cfg_q.gain_prop  <= 16'd256;
      cfg_q.gain_integ <= 16'd16;
      cfg_q.gain_deriv <= 16'd0;
      cfg_q.cycle_ms   <= 16'd5000;
      cfg_q.min_on_ms  <= 15'd1000;
      gap_q            <= 16'd250;
      cfg_q.integ_band <= 12'd12;
    end else if (cfg_we_i) begin
      unique case (tph_pkg::cfg_idx_e'(cfg_index_i))
        tph_pkg::CFG_TARGET:     cfg_q.target <= (cfg_data_i[10:0] > tph_pkg::TARGET_CAP) ?
                                                 tph_pkg::TARGET_CAP : cfg_data_i[10:0];
        tph_pkg::CFG_GAIN_PROP:  cfg_q.gain_prop  <= cfg_data_i;
        tph_pkg::CFG_GAIN_INTEG: cfg_q.gain_integ <= cfg_data_i;
        tph_pkg::CFG_GAIN_DERIV: cfg_q.gain_deriv <= cfg_data_i;
        tph_pkg::CFG_CYCLE:      cfg_q.cycle_ms   <= cfg_data_i;
        tph_pkg::CFG_MIN_ON:     cfg_q.min_on_ms  <= cfg_data_i[14:0];
        tph_pkg::CFG_GAP:        gap_q            <= cfg_data_i;
        tph_pkg::CFG_BAND:       cfg_q.integ_band <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tph_pkg::T_IDLE:   if (accept) state_d = pid_start ? tph_pkg::T_CALC : tph_pkg::T_SWITCH;
      tph_pkg::T_CALC:   if (pid_done) state_d = tph_pkg::T_SWITCH;
      tph_pkg::T_SWITCH: if (load_out) state_d = tph_pkg::T_IDLE;
      default:           state_d = tph_pkg::T_IDLE;
    endcase
  end

  // item processing
  always_comb begin
    active_d  = active_q;
    heater_d  = heater_q;
    sel_d     = sel_q;
    fault_d   = fault_q;
    tick_d    = tick_q;
    read_d    = read_q;
    sw_d      = sw_q;
    rd_d      = rd_q;
    ss_d      = ss_q;
    duty_d    = duty_q;
    temp_d    = temp_q;
    pid_start = 1'b0;
    unique case (state_q)
      tph_pkg::T_IDLE: begin
        if (accept) begin
          tick_d = 1'b0;
          read_d = 1'b0;
          case (tph_pkg::op_e'(op_i))
            tph_pkg::OP_START: active_d = 1'b1;
            tph_pkg::OP_STOP: begin
              active_d = 1'b0;
              heater_d = 1'b0;
              sw_d     = '0;
            end
            tph_pkg::OP_TICK: begin
              sw_d   = bump(sw_q);
              rd_d   = bump(rd_q);
              ss_d   = bump(ss_q);
              tick_d = active_q;
              if (active_q) begin
                if (sel_q && (ss_d != '0)) begin
                  read_d = 1'b1;
                  sel_d  = 1'b0;
                  if (sensor_word_i[tph_pkg::OPEN_BIT]) begin
                    fault_d = 1'b1;
                    duty_d  = '0;
                  end else begin
                    fault_d   = 1'b0;
                    temp_d    = sensor_word_i[14:3];
                    pid_start = 1'b1;
                  end
                  rd_d = '0;
                end
                if (!sel_d && (rd_d > COUNT_BITS'(gap_q))) begin
                  sel_d = 1'b1;
                  ss_d  = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      tph_pkg::T_CALC: begin
        if (pid_done) duty_d = pid_duty;
      end
      tph_pkg::T_SWITCH: begin
        if (load_out && tick_q) begin
          if (heater_q && (sw_q > COUNT_BITS'(duty_q)) && (duty_q < cfg_q.cycle_ms)) begin
            heater_d = 1'b0;
            sw_d     = '0;
          end else if (!heater_q && (duty_q != '0) &&
                       ((duty_q > cfg_q.cycle_ms) ||
                        (sw_q > COUNT_BITS'(cfg_q.cycle_ms - duty_q)))) begin
            heater_d = 1'b1;
            sw_d     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (load_out) ov_d = 1'b1;
  end

  tph_pid #(
    .COUNT_BITS (COUNT_BITS)
  ) u_pid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pid_start),
    .temp_i    (temp_d),
    .cfg_i     (cfg_q),
    .elapsed_i (rd_q + COUNT_BITS'(rd_q != CNT_MAX)),
    .done_o    (pid_done),
    .duty_o    (pid_duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tph_pkg::T_IDLE;
      active_q <= 1'b0;
      heater_q <= 1'b0;
      sel_q    <= 1'b0;
      fault_q  <= 1'b0;
      tick_q   <= 1'b0;
      read_q   <= 1'b0;
      sw_q     <= '0;
      rd_q     <= '0;
      ss_q     <= '0;
      duty_q   <= '0;
      temp_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      heater_q <= heater_d;
      sel_q    <= sel_d;
      fault_q  <= fault_d;
      tick_q   <= tick_d;
      read_q   <= read_d;
      sw_q     <= sw_d;
      rd_q     <= rd_d;
      ss_q     <= ss_d;
      duty_q   <= duty_d;
      temp_q   <= temp_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_heater_q <= heater_d;
      o_sel_q    <= sel_q;
      o_read_q   <= read_q;
      o_temp_q   <= temp_q;
      o_fault_q  <= fault_q;
      o_duty_q   <= duty_q;
      o_run_q    <= active_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign heater_on_o     = o_heater_q;
  assign sensor_select_o = o_sel_q;
  assign sensor_read_o   = o_read_q;
  assign temperature_o   = o_temp_q;
  assign open_circuit_o  = o_fault_q;
  assign duty_ms_o       = o_duty_q;
  assign running_o       = o_run_q;

endmodule

@@ hw/rtl/tph_checker.sv @@
// ----------------------------------------------------------------------------
// tph_checker
// Port-level checks for the heater controller, bound to the top level.
// ----------------------------------------------------------------------------
module tph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        heater_on_o,
  input logic        sensor_read_o,
  input logic        open_circuit_o,
  input logic [15:0] duty_ms_o,
  input logic        running_o
);

  // held result keeps its duty
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_ms_o))
    else $error("stalled result changed");

  // an open thermocouple forces zero duty
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_circuit_o |-> duty_ms_o == 16'd0)
    else $error("duty nonzero with open circuit");

  // heater never drives in standby
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> !heater_on_o)
    else $error("heater on while stopped");

  // sensor is only read while running
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_read_o |-> running_o)
    else $error("sensor read in standby");

endmodule

bind time_proportioned_pid_heater_top tph_checker u_tph_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .heater_on_o    (heater_on_o),
  .sensor_read_o  (sensor_read_o),
  .open_circuit_o (open_circuit_o),
  .duty_ms_o      (duty_ms_o),
  .running_o      (running_o)
);

@@ tb/sv/time_proportioned_pid_heater_top_tb.sv @@
// ----------------------------------------------------------------------------
// time_proportioned_pid_heater_top_tb
// Drives ticks, start/stop events and converter words into the heater
// controller, predicts every result in a local PID and sequencer model, and
// checks each output transfer field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module time_proportioned_pid_heater_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic        heater;
    logic        sel;
    logic        rd;
    logic [11:0] temp;
    logic        open;
    logic [15:0] duty;
    logic        run;
  } heat_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [15:0] sensor_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        heater_on_o, sensor_select_o, sensor_read_o, open_circuit_o, running_o;
  logic [11:0] temperature_o;
  logic [15:0] duty_ms_o;

  time_proportioned_pid_heater_top dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor copy of registers and state
  int unsigned     m_target, m_gp, m_gi, m_gd, m_cycle, m_min_on, m_gap, m_band;
  bit              m_run, m_heat, m_sel, m_fault;
  longint unsigned m_sw, m_rd, m_selc;
  longint          m_last_err, m_integ;
  int unsigned     m_duty, m_temp;

  heat_res_t expected_q[$];
  int        err_count = 0;
  bit        quiet = 1'b0;
  int        hold_req = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  function automatic heat_res_t predict_step(input tph_pkg::op_e op, input logic [15:0] w);
    heat_res_t r;
    bit        rd;
    longint    e, ae, delta, d, raw, dv, cyc, mn;
    longint unsigned mag, q;
    rd = 1'b0;
    if (op == tph_pkg::OP_START) begin
      m_run = 1'b1;
    end else if (op == tph_pkg::OP_STOP) begin
      m_run = 1'b0;
      m_heat = 1'b0;
      m_sw = 0;
    end else if (op == tph_pkg::OP_TICK) begin
      if (m_sw < CNT_MAX) m_sw++;
      if (m_rd < CNT_MAX) m_rd++;
      if (m_selc < CNT_MAX) m_selc++;
      if (m_run) begin
        if (m_sel && m_selc >= 1) begin
          rd = 1'b1;
          m_sel = 1'b0;
          if (w[tph_pkg::OPEN_BIT]) begin
            m_fault = 1'b1;
            m_duty = 0;
          end else begin
            m_fault = 1'b0;
            m_temp = 32'(w[14:3]);
            e = longint'(m_target) - longint'(m_temp);
            ae = e < 0 ? -e : e;
            if (ae < longint'(m_band)) begin
              m_integ += longint'(m_gi) * e;
              if (m_integ > 64'sd2147483647) m_integ = 64'sd2147483647;
              if (m_integ < -64'sd2147483648) m_integ = -64'sd2147483648;
            end
            d = 0;
            if (m_rd != 0) begin
              delta = e - m_last_err;
              mag = delta < 0 ? -delta : delta;
              q = (longint'(m_gd) * mag * 1000) / m_rd;
              d = delta < 0 ? -longint'(q) : longint'(q);
            end
            raw = longint'(m_gp) * e + m_integ + d;
            cyc = longint'(m_cycle);
            mn = longint'(m_min_on);
            if (raw < 0) begin
              dv = 0;
            end else begin
              dv = raw >>> 8;
              if (dv < mn) dv = mn;
            end
            if (dv > cyc) dv = cyc;
            else if (dv > cyc - mn) dv = cyc - mn;
            if (dv < 0) dv = 0;
            m_duty = 32'(dv & 16'hFFFF);
            m_last_err = e;
          end
          m_rd = 0;
        end
        if (!m_sel && m_rd > m_gap) begin
          m_sel = 1'b1;
          m_selc = 0;
        end
        if (m_heat && m_sw > m_duty && m_duty < m_cycle) begin
          m_heat = 1'b0;
          m_sw = 0;
        end else if (!m_heat && m_duty > 0 &&
                     (m_duty > m_cycle || m_sw > longint'(m_cycle) - longint'(m_duty))) begin
          m_heat = 1'b1;
          m_sw = 0;
        end
      end
    end
    r.heater = m_heat;
    r.sel = m_sel;
    r.rd = rd;
    r.temp = m_temp[11:0];
    r.open = m_fault;
    r.duty = m_duty[15:0];
    r.run = m_run;
    return r;
  endfunction

  // one input transfer; valid stays high unless the sender idles
  task automatic send_item(input tph_pkg::op_e op, input logic [15:0] w);
    in_valid_i <= 1'b1;
    op_i <= op;
    sensor_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_step(op, w));
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input tph_pkg::cfg_idx_e idx, input logic [15:0] v);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tph_pkg::CFG_TARGET:
        m_target = 32'(v[10:0] > tph_pkg::TARGET_CAP ? tph_pkg::TARGET_CAP : v[10:0]);
      tph_pkg::CFG_GAIN_PROP:  m_gp = 32'(v);
      tph_pkg::CFG_GAIN_INTEG: m_gi = 32'(v);
      tph_pkg::CFG_GAIN_DERIV: m_gd = 32'(v);
      tph_pkg::CFG_CYCLE:      m_cycle = 32'(v);
      tph_pkg::CFG_MIN_ON:     m_min_on = 32'(v[14:0]);
      tph_pkg::CFG_GAP:        m_gap = 32'(v);
      tph_pkg::CFG_BAND:       m_band = 32'(v[11:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] t, gp, gi, gd, cyc, mn, gap, band);
    write_reg(tph_pkg::CFG_TARGET, t);
    write_reg(tph_pkg::CFG_GAIN_PROP, gp);
    write_reg(tph_pkg::CFG_GAIN_INTEG, gi);
    write_reg(tph_pkg::CFG_GAIN_DERIV, gd);
    write_reg(tph_pkg::CFG_CYCLE, cyc);
    write_reg(tph_pkg::CFG_MIN_ON, mn);
    write_reg(tph_pkg::CFG_GAP, gap);
    write_reg(tph_pkg::CFG_BAND, band);
  endtask

  function automatic logic [15:0] near_word(input int spread);
    int t;
    t = int'(m_target) + $urandom_range(2 * spread) - spread;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return {1'($urandom_range(1)), 12'(t), 1'b0, 2'($urandom_range(3))};
  endfunction

  // receiver: check each result, drive stall
  always @(posedge clk_i or negedge rst_ni) begin
    heat_res_t want;
    int hold_cnt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (heater_on_o !== want.heater)
            report("heater_on", int'(heater_on_o), int'(want.heater));
          if (sensor_select_o !== want.sel)
            report("sensor_select", int'(sensor_select_o), int'(want.sel));
          if (sensor_read_o !== want.rd)
            report("sensor_read", int'(sensor_read_o), int'(want.rd));
          if (temperature_o !== want.temp)
            report("temperature", int'(temperature_o), int'(want.temp));
          if (open_circuit_o !== want.open)
            report("open_circuit", int'(open_circuit_o), int'(want.open));
          if (duty_ms_o !== want.duty)
            report("duty_ms", int'(duty_ms_o), int'(want.duty));
          if (running_o !== want.run)
            report("running", int'(running_o), int'(want.run));
        end
      end
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  task automatic test_directed();
    send_item(tph_pkg::OP_NOP, 16'h0000);
    send_item(tph_pkg::OP_STOP, 16'hFFFF);
    send_item(tph_pkg::OP_TICK, 16'h0000);      // tick in standby
    write_reg(tph_pkg::CFG_GAP, 16'd1);
    send_item(tph_pkg::OP_START, 16'h0000);
    send_item(tph_pkg::OP_START, 16'h0000);
    repeat (3) send_item(tph_pkg::OP_TICK, 16'h0000);   // temperature zero
    repeat (3) send_item(tph_pkg::OP_TICK, 16'h7FF8);   // max reading, no fault
    repeat (3) send_item(tph_pkg::OP_TICK, 16'hFFFF);   // open thermocouple
    repeat (3) send_item(tph_pkg::OP_TICK, 16'h0004);
    repeat (3) send_item(tph_pkg::OP_TICK, {1'b0, 12'd800, 3'b000}); // on target
    send_item(tph_pkg::OP_NOP, 16'hFFFF);
    send_item(tph_pkg::OP_STOP, 16'h0000);
    send_item(tph_pkg::OP_STOP, 16'h0000);
  endtask

  task automatic test_extremes();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65535, 16'hFFFF, 16'd1, 16'hFFFF);
    send_item(tph_pkg::OP_START, 16'h0);
    repeat (30) send_item(tph_pkg::OP_TICK, near_word(30));
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd2, 16'd0);
    repeat (30) send_item(tph_pkg::OP_TICK, 16'($urandom_range(16'hFFFF)));
    write_all(16'd1400, 16'd65535, 16'd100, 16'd0, 16'd10, 16'd32767, 16'd1, 16'd4095);
    repeat (30) send_item(tph_pkg::OP_TICK, near_word(200));
    write_reg(tph_pkg::CFG_GAP, 16'd65535);
    repeat (20) send_item(tph_pkg::OP_TICK, near_word(10));
    send_item(tph_pkg::OP_STOP, 16'h0);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_all(16'($urandom_range(1600)), 16'($urandom_range(2000)),
                16'($urandom_range(400)), 16'($urandom_range(64)),
                16'($urandom_range(1, 60)), 16'($urandom_range(20)),
                16'($urandom_range(1, 6)), 16'($urandom_range(40)));
      quiet = (ph == 2);
      send_item(tph_pkg::OP_START, 16'($urandom_range(16'hFFFF)));
      for (int i = 0; i < 195; i++) begin
        int k;
        k = $urandom_range(99);
        if (k < 2) send_item(tph_pkg::OP_NOP, 16'($urandom_range(16'hFFFF)));
        else if (k < 4) send_item(tph_pkg::OP_STOP, 16'($urandom_range(16'hFFFF)));
        else if (k < 7) send_item(tph_pkg::OP_START, 16'($urandom_range(16'hFFFF)));
        else if (k < 17) send_item(tph_pkg::OP_TICK, 16'($urandom_range(16'hFFFF)));
        else send_item(tph_pkg::OP_TICK, near_word(25));
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(tph_pkg::CFG_GAP, 16'd1);
    send_item(tph_pkg::OP_START, 16'h0);
    hold_req = 400;
    repeat (40) send_item(tph_pkg::OP_TICK, near_word(15));
  endtask

  initial begin
    m_target = 800; m_gp = 256; m_gi = 16; m_gd = 0;
    m_cycle = 5000; m_min_on = 1000; m_gap = 250; m_band = 12;
    m_run = 0; m_heat = 0; m_sel = 0; m_fault = 0;
    m_sw = 0; m_rd = 0; m_selc = 0;
    m_last_err = 0; m_integ = 0; m_duty = 0; m_temp = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extremes();
    test_random();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
